// ===== hdl/lwsd_pkg.sv =====
// Shared types and constants for the local window standard deviation filter.
package lwsd_pkg;

	localparam int COL_W  = 11;
	localparam int ROW_W  = 13;
	localparam int SLOT_W = 4;
	localparam int PIX_W  = 8;
	localparam int SD_W   = 11;
	localparam int QUEUE_DEPTH = 4;
	localparam int QPTR_W = 2;

	localparam logic [SD_W-1:0] SD_MAX = 11'd2047;

	// Register indexes
	localparam logic [1:0] REG_WIDTH  = 2'd0;
	localparam logic [1:0] REG_HEIGHT = 2'd1;
	localparam logic [1:0] REG_HALF   = 2'd2;

	// Effective frame geometry
	typedef struct packed {
		logic [COL_W-1:0] w;
		logic [ROW_W-1:0] h;
		logic [1:0]       half;
	} geom_t;

	// Command from front to back: optional store write, optional result job
	typedef struct packed {
		logic              wr_en;
		logic [SLOT_W-1:0] wr_slot;
		logic [COL_W-1:0]  wr_col;
		logic [PIX_W-1:0]  wr_data;
		logic              job_en;
		logic              last;
		logic [SLOT_W-1:0] slot;
		logic [ROW_W-1:0]  row;
		logic [COL_W-1:0]  col;
	} cmd_t;

	typedef enum logic [3:0] {
		BK_IDLE,
		BK_SCAN,
		BK_FLUSH,
		BK_MUL,
		BK_SUB,
		BK_SQRT,
		BK_DINIT,
		BK_DIV,
		BK_DONE
	} bk_state_t;

endpackage

// ===== hdl/local_window_std_deviation.sv =====
// Top level: configuration registers, front end, command queue and back end.
//
// Red bytes stream in on the slave side in raster order and one local
// standard deviation (Q7.4, saturating at 2047) per pixel streams out on the
// master side, trailing the input by half*width+half pixels; after the frame's
// last pixel, drain beats (tuser=1) push out the rest, tlast marks the final
// result. The front end takes one beat per cycle while the four-entry command
// queue has room. Each result costs the back end a scan that reads the window
// one pixel a cycle from the line store, then a bit-serial square root and a
// bit-serial division of R steps each, where R is the root width (18 at the
// default MAX_HALF). A pixel that produces no result costs the back end only
// its store write. A write to the width, height or half register restarts the
// frame; the line store keeps its data.
module local_window_std_deviation
	import lwsd_pkg::*;
#(
	parameter int MAX_WIDTH = 1024,
	parameter int MAX_HALF  = 3
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        psel,
	input  logic        penable,
	input  logic        pwrite,
	input  logic [3:0]  paddr,
	input  logic [31:0] pwdata,
	output logic [31:0] prdata,
	output logic        pready,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [7:0]  s_tdata,   // [7:0] red_sample
	input  logic        s_tuser,   // [0] drain
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [15:0] m_tdata,   // [10:0] std_dev_q4, [15:11] zero
	output logic        m_tlast    // frame_last
);

	localparam int LAG_W = $clog2(MAX_HALF * MAX_WIDTH + MAX_HALF + 2);

	logic [COL_W-1:0] image_width_q;
	logic [ROW_W-1:0] image_height_q;
	logic [1:0]       window_half_q;

	logic cfg_wr, clr;
	logic [1:0] reg_idx;
	geom_t geo;
	logic [12:0] lag_prod;
	logic [LAG_W-1:0] lag;

	logic push, pop, q_full, q_empty;
	cmd_t push_cmd, pop_cmd;

	assign pready  = 1'b1;
	assign reg_idx = paddr[3:2];
	assign cfg_wr  = psel && penable && pwrite && pready;
	assign clr     = cfg_wr && (reg_idx == REG_WIDTH || reg_idx == REG_HEIGHT
		|| reg_idx == REG_HALF);

	// Configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			image_width_q  <= 11'd640;
			image_height_q <= 13'd480;
			window_half_q  <= 2'd1;
		end else if (cfg_wr) begin
			case (reg_idx)
				REG_WIDTH:  image_width_q  <= pwdata[COL_W-1:0];
				REG_HEIGHT: image_height_q <= pwdata[ROW_W-1:0];
				REG_HALF:   window_half_q  <= pwdata[1:0];
				default: ;
			endcase
		end
	end

	// Read back
	always_comb begin
		case (reg_idx)
			REG_WIDTH:  prdata = {21'b0, image_width_q};
			REG_HEIGHT: prdata = {19'b0, image_height_q};
			REG_HALF:   prdata = {30'b0, window_half_q};
			default:    prdata = '0;
		endcase
	end

	// Effective geometry and result lag
	always_comb begin
		if (image_width_q == '0)                   geo.w = COL_W'(1);
		else if (int'(image_width_q) > MAX_WIDTH) geo.w = COL_W'(MAX_WIDTH);
		else                                       geo.w = image_width_q;
		geo.h    = (image_height_q == '0) ? ROW_W'(1) : image_height_q;
		geo.half = (int'(window_half_q) > MAX_HALF) ? 2'(MAX_HALF) : window_half_q;
		lag_prod = 13'(geo.w) * 13'(geo.half);
		lag      = LAG_W'(lag_prod + 13'(geo.half));
	end

	lwsd_front #(
		.MAX_HALF (MAX_HALF),
		.LAG_W    (LAG_W)
	) u_front (
		.clk      (clk),
		.arst_n   (arst_n),
		.clr      (clr),
		.geo      (geo),
		.lag      (lag),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.s_tuser  (s_tuser),
		.q_full   (q_full),
		.push     (push),
		.push_cmd (push_cmd)
	);

	lwsd_queue u_queue (
		.clk      (clk),
		.arst_n   (arst_n),
		.push     (push),
		.push_cmd (push_cmd),
		.pop      (pop),
		.pop_cmd  (pop_cmd),
		.full     (q_full),
		.empty    (q_empty)
	);

	lwsd_back #(
		.MAX_WIDTH (MAX_WIDTH),
		.MAX_HALF  (MAX_HALF)
	) u_back (
		.clk      (clk),
		.arst_n   (arst_n),
		.geo      (geo),
		.q_empty  (q_empty),
		.q_cmd    (pop_cmd),
		.pop      (pop),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.m_tlast  (m_tlast)
	);

endmodule

// ===== hdl/lwsd_front.sv =====
// Front end: accepts beats, tracks raster positions and issues commands.
module lwsd_front
	import lwsd_pkg::*;
#(
	parameter int MAX_HALF = 3,
	parameter int LAG_W    = 12
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             clr,
	input  geom_t            geo,
	input  logic [LAG_W-1:0] lag,
	input  logic             s_tvalid,
	output logic             s_tready,
	input  logic [7:0]       s_tdata,
	input  logic             s_tuser,
	input  logic             q_full,
	output logic             push,
	output cmd_t             push_cmd
);

	localparam int STORE_ROWS = 2 * MAX_HALF + 2;
	localparam logic [SLOT_W-1:0] SLOT_LAST = SLOT_W'(STORE_ROWS - 1);

	logic [COL_W-1:0]  in_col_q, out_col_q;
	logic [ROW_W-1:0]  in_row_q, out_row_q;
	logic [SLOT_W-1:0] in_slot_q, out_slot_q;
	logic [LAG_W-1:0]  pend_q;

	logic acc, all_in, do_wr, do_job, last;
	logic [LAG_W-1:0] pend_inc;

	assign s_tready = !q_full;

	// Classify the beat
	always_comb begin
		acc      = s_tvalid && s_tready;
		all_in   = (in_row_q == geo.h);
		do_wr    = acc && !s_tuser && !all_in;
		pend_inc = pend_q + LAG_W'(1);
		do_job   = (do_wr && (pend_inc > lag)) || (acc && s_tuser && all_in);
		last     = (out_row_q == geo.h - ROW_W'(1)) && (out_col_q == geo.w - COL_W'(1));
		push     = do_wr || do_job;
		push_cmd = '{wr_en: do_wr, wr_slot: in_slot_q, wr_col: in_col_q, wr_data: s_tdata,
			job_en: do_job, last: last, slot: out_slot_q, row: out_row_q, col: out_col_q};
	end

	// Position counters
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			in_col_q   <= '0;
			in_row_q   <= '0;
			in_slot_q  <= '0;
			out_col_q  <= '0;
			out_row_q  <= '0;
			out_slot_q <= '0;
			pend_q     <= '0;
		end else if (clr || (do_job && last)) begin
			in_col_q   <= '0;
			in_row_q   <= '0;
			in_slot_q  <= '0;
			out_col_q  <= '0;
			out_row_q  <= '0;
			out_slot_q <= '0;
			pend_q     <= '0;
		end else begin
			if (do_wr) begin
				if (in_col_q == geo.w - COL_W'(1)) begin
					in_col_q  <= '0;
					in_row_q  <= in_row_q + ROW_W'(1);
					in_slot_q <= (in_slot_q == SLOT_LAST) ? '0 : in_slot_q + SLOT_W'(1);
				end else begin
					in_col_q <= in_col_q + COL_W'(1);
				end
			end
			if (do_job) begin
				if (out_col_q == geo.w - COL_W'(1)) begin
					out_col_q  <= '0;
					out_row_q  <= out_row_q + ROW_W'(1);
					out_slot_q <= (out_slot_q == SLOT_LAST) ? '0 : out_slot_q + SLOT_W'(1);
				end else begin
					out_col_q <= out_col_q + COL_W'(1);
				end
			end
			if (do_wr && !do_job) begin
				pend_q <= pend_inc;
			end else if (!do_wr && do_job) begin
				pend_q <= pend_q - LAG_W'(1);
			end
		end
	end

endmodule

// ===== hdl/lwsd_queue.sv =====
// Small command queue between front and back.
module lwsd_queue
	import lwsd_pkg::*;
(
	input  logic clk,
	input  logic arst_n,
	input  logic push,
	input  cmd_t push_cmd,
	input  logic pop,
	output cmd_t pop_cmd,
	output logic full,
	output logic empty
);

	cmd_t              slots_q [QUEUE_DEPTH];
	logic [QPTR_W-1:0] wptr_q, rptr_q;
	logic [QPTR_W:0]   count_q;

	assign full    = (count_q == (QPTR_W+1)'(QUEUE_DEPTH));
	assign empty   = (count_q == '0);
	assign pop_cmd = slots_q[rptr_q];

	// Storage
	always_ff @(posedge clk) begin
		if (push) begin
			slots_q[wptr_q] <= push_cmd;
		end
	end

	// Pointers and fill count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wptr_q  <= '0;
			rptr_q  <= '0;
			count_q <= '0;
		end else begin
			if (push) wptr_q <= wptr_q + QPTR_W'(1);
			if (pop)  rptr_q <= rptr_q + QPTR_W'(1);
			if (push && !pop) begin
				count_q <= count_q + (QPTR_W+1)'(1);
			end else if (!push && pop) begin
				count_q <= count_q - (QPTR_W+1)'(1);
			end
		end
	end

endmodule

// ===== hdl/lwsd_back.sv =====
// Back end: line store, window scan, square root, division and result register.
module lwsd_back
	import lwsd_pkg::*;
#(
	parameter int MAX_WIDTH = 1024,
	parameter int MAX_HALF  = 3
) (
	input  logic        clk,
	input  logic        arst_n,
	input  geom_t       geo,
	input  logic        q_empty,
	input  cmd_t        q_cmd,
	output logic        pop,
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [15:0] m_tdata,
	output logic        m_tlast
);

	localparam int STORE_ROWS = 2 * MAX_HALF + 2;
	localparam int DEPTH  = STORE_ROWS * MAX_WIDTH;
	localparam int ADDR_W = $clog2(DEPTH);
	localparam int WMAX   = (2 * MAX_HALF + 1) * (2 * MAX_HALF + 1);
	localparam int N_W    = $clog2(WMAX + 1);
	localparam int S1_W   = $clog2(WMAX * 255 + 1);
	localparam int S2_W   = $clog2(WMAX * 65025 + 1);
	localparam int P_W    = N_W + S2_W;
	localparam int R_W    = (P_W + 9) / 2;
	localparam int ITER_W = $clog2(R_W + 1);
	localparam int Y_W    = ROW_W + 2;
	localparam int X_W    = COL_W + 2;

	logic [PIX_W-1:0] mem [DEPTH];

	bk_state_t state_q, state_d;

	logic [SLOT_W-1:0] slot_q;
	logic signed [Y_W-1:0] y_q;
	logic signed [X_W-1:0] x_q, x0_q;
	logic [2:0] ky_q, kx_q, kmax;
	logic last_q;

	logic [PIX_W-1:0] rd_s1;
	logic v_s1;
	logic [N_W-1:0]  n_q;
	logic [S1_W-1:0] s1_q;
	logic [S2_W-1:0] s2_q;
	logic [P_W-1:0]  ns2_q, s1sq_q;

	logic [2*R_W-1:0] rad_q;
	logic [R_W+1:0]   rem_q, rem_n, trial;
	logic [R_W-1:0]   root_q;
	logic [N_W:0]     drem_q, drem_n;
	logic [R_W-1:0]   dq_q;
	logic [ITER_W-1:0] iter_q;

	logic valid_pos, scan_end, out_load;
	logic [ADDR_W-1:0] raddr, waddr;
	logic [SLOT_W:0] slot_wide;
	logic [SD_W-1:0] sd;

	logic m_tvalid_q, m_tlast_q;
	logic [SD_W-1:0] m_sd_q;

	assign m_tvalid = m_tvalid_q;
	assign m_tlast  = m_tlast_q;
	assign m_tdata  = {{(16 - SD_W){1'b0}}, m_sd_q};

	// Window position and addressing
	always_comb begin
		kmax      = {geo.half, 1'b0};
		valid_pos = (y_q >= 0) && (y_q < $signed({2'b00, geo.h}))
			&& (x_q >= 0) && (x_q < $signed({2'b00, geo.w}));
		raddr     = valid_pos
			? ADDR_W'(slot_q) * ADDR_W'(MAX_WIDTH) + ADDR_W'(x_q[COL_W-1:0]) : '0;
		waddr     = ADDR_W'(q_cmd.wr_slot) * ADDR_W'(MAX_WIDTH) + ADDR_W'(q_cmd.wr_col);
		scan_end  = (ky_q == kmax) && (kx_q == kmax);
		slot_wide = (q_cmd.slot >= SLOT_W'(geo.half))
			? {1'b0, q_cmd.slot} - (SLOT_W+1)'(geo.half)
			: {1'b0, q_cmd.slot} + (SLOT_W+1)'(STORE_ROWS) - (SLOT_W+1)'(geo.half);
		rem_n     = {rem_q[R_W-1:0], rad_q[2*R_W-1 -: 2]};
		trial     = {root_q, 2'b01};
		drem_n    = {drem_q[N_W-1:0], dq_q[R_W-1]};
		sd        = (|dq_q[R_W-1:SD_W]) ? SD_MAX : dq_q[SD_W-1:0];
		out_load  = (state_q == BK_DONE) && (!m_tvalid_q || m_tready);
	end

	// Line store
	always_ff @(posedge clk) begin
		if (pop && q_cmd.wr_en) begin
			mem[waddr] <= q_cmd.wr_data;
		end
		rd_s1 <= mem[raddr];
	end

	// State register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) state_q <= BK_IDLE;
		else         state_q <= state_d;
	end

	// Next state
	always_comb begin
		state_d = state_q;
		pop     = 1'b0;
		case (state_q)
			BK_IDLE: begin
				if (!q_empty) begin
					pop = 1'b1;
					if (q_cmd.job_en) state_d = BK_SCAN;
				end
			end
			BK_SCAN:  if (scan_end) state_d = BK_FLUSH;
			BK_FLUSH: state_d = BK_MUL;
			BK_MUL:   state_d = BK_SUB;
			BK_SUB:   state_d = BK_SQRT;
			BK_SQRT:  if (iter_q == ITER_W'(R_W - 1)) state_d = BK_DINIT;
			BK_DINIT: state_d = BK_DIV;
			BK_DIV:   if (iter_q == ITER_W'(R_W - 1)) state_d = BK_DONE;
			BK_DONE:  if (out_load) state_d = BK_IDLE;
			default:  state_d = BK_IDLE;
		endcase
	end

	// Read valid pipeline
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) v_s1 <= 1'b0;
		else         v_s1 <= (state_q == BK_SCAN) && valid_pos;
	end

	// Datapath
	always_ff @(posedge clk) begin
		if (v_s1) begin
			n_q  <= n_q + N_W'(1);
			s1_q <= s1_q + S1_W'(rd_s1);
			s2_q <= s2_q + S2_W'(rd_s1 * rd_s1);
		end
		case (state_q)
			BK_IDLE: begin
				if (pop && q_cmd.job_en) begin
					last_q <= q_cmd.last;
					slot_q <= slot_wide[SLOT_W-1:0];
					y_q    <= $signed({2'b00, q_cmd.row}) - $signed(Y_W'(geo.half));
					x0_q   <= $signed({2'b00, q_cmd.col}) - $signed(X_W'(geo.half));
					x_q    <= $signed({2'b00, q_cmd.col}) - $signed(X_W'(geo.half));
					ky_q   <= '0;
					kx_q   <= '0;
					n_q    <= '0;
					s1_q   <= '0;
					s2_q   <= '0;
				end
			end
			BK_SCAN: begin
				if (kx_q == kmax) begin
					kx_q   <= '0;
					x_q    <= x0_q;
					ky_q   <= ky_q + 3'd1;
					y_q    <= y_q + Y_W'(1);
					slot_q <= (slot_q == SLOT_W'(STORE_ROWS - 1)) ? '0 : slot_q + SLOT_W'(1);
				end else begin
					kx_q <= kx_q + 3'd1;
					x_q  <= x_q + X_W'(1);
				end
			end
			BK_MUL: begin
				ns2_q  <= P_W'(n_q) * P_W'(s2_q);
				s1sq_q <= P_W'(s1_q * s1_q);
			end
			BK_SUB: begin
				rad_q  <= (2*R_W)'({ns2_q - s1sq_q, 8'h00});
				rem_q  <= '0;
				root_q <= '0;
				iter_q <= '0;
			end
			BK_SQRT: begin
				rad_q  <= {rad_q[2*R_W-3:0], 2'b00};
				iter_q <= iter_q + ITER_W'(1);
				if (rem_n >= trial) begin
					rem_q  <= rem_n - trial;
					root_q <= {root_q[R_W-2:0], 1'b1};
				end else begin
					rem_q  <= rem_n;
					root_q <= {root_q[R_W-2:0], 1'b0};
				end
			end
			BK_DINIT: begin
				dq_q   <= root_q;
				drem_q <= '0;
				iter_q <= '0;
			end
			BK_DIV: begin
				iter_q <= iter_q + ITER_W'(1);
				if (drem_n >= {1'b0, n_q}) begin
					drem_q <= drem_n - {1'b0, n_q};
					dq_q   <= {dq_q[R_W-2:0], 1'b1};
				end else begin
					drem_q <= drem_n;
					dq_q   <= {dq_q[R_W-2:0], 1'b0};
				end
			end
			default: ;
		endcase
	end

	// Result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_tvalid_q <= 1'b0;
		end else if (out_load) begin
			m_tvalid_q <= 1'b1;
		end else if (m_tready) begin
			m_tvalid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (out_load) begin
			m_sd_q    <= sd;
			m_tlast_q <= last_q;
		end
	end

	// Read data is only marked valid during the window scan and its flush
	a_valid_scan: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q != BK_SCAN && state_q != BK_FLUSH) |-> !v_s1)
		else $error("store read valid outside window scan");

	a_sqrt_iter: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == BK_SQRT || state_q == BK_DIV) |-> (iter_q < ITER_W'(R_W)))
		else $error("iteration count overrun");

	a_out_load: assert property (@(posedge clk) disable iff (!arst_n)
		out_load |=> (m_tvalid && state_q == BK_IDLE))
		else $error("finished result not presented");

endmodule

// ===== dv/tb_local_window_std_deviation.sv =====
// Testbench for the local window standard deviation filter: directed and random frames, scoreboard check.
module tb_local_window_std_deviation;
	import lwsd_pkg::*;

	// Predicts the filter output from the accepted beats and checks each result against it
	class lwsd_scoreboard;
		typedef struct {
			bit [10:0] sd;
			bit        last;
		} sd_result_t;

		bit [7:0]    lines [8*1024];
		int unsigned width_reg = 640, height_reg = 480, half_reg = 1;
		int unsigned in_col, in_row, out_col, out_row;
		sd_result_t  owed [$];
		int          errors;

		function void clear_pos();
			in_col = 0; in_row = 0; out_col = 0; out_row = 0;
		endfunction

		function void write_reg(logic [1:0] idx, int unsigned v);
			case (idx)
				REG_WIDTH:  width_reg  = v & 32'h7FF;
				REG_HEIGHT: height_reg = v & 32'h1FFF;
				REG_HALF:   half_reg   = v & 32'h3;
				default:    return;
			endcase
			clear_pos();
		endfunction

		function int unsigned eff_w();
			return (width_reg == 0) ? 1 : ((width_reg > 1024) ? 1024 : width_reg);
		endfunction

		function int unsigned eff_h();
			return (height_reg == 0) ? 1 : height_reg;
		endfunction

		function int unsigned eff_half();
			return (half_reg > 3) ? 3 : half_reg;
		endfunction

		// bitwise integer square root
		function longint unsigned int_root(longint unsigned x);
			longint unsigned res, bt;
			res = 0;
			bt = 64'd1 << 62;
			while (bt > x) bt >>= 2;
			while (bt != 0) begin
				if (x >= res + bt) begin
					x -= res + bt;
					res = (res >> 1) + bt;
				end else begin
					res >>= 1;
				end
				bt >>= 2;
			end
			return res;
		endfunction

		function bit [10:0] window_sd(int r, int c, int w, int h, int hf);
			longint unsigned n, s1, s2, v, q;
			int y, x;
			n = 0; s1 = 0; s2 = 0;
			for (int dy = -hf; dy <= hf; dy++) begin
				y = r + dy;
				if (y < 0 || y >= h) continue;
				for (int dx = -hf; dx <= hf; dx++) begin
					x = c + dx;
					if (x < 0 || x >= w) continue;
					v = lines[(y % 8) * 1024 + x];
					n++;
					s1 += v;
					s2 += v * v;
				end
			end
			if (n == 0) return 0;
			q = int_root((n * s2 - s1 * s1) * 256) / n;
			return (q > 2047) ? SD_MAX : q[10:0];
		endfunction

		function void note_beat(bit [7:0] red, bit drn);
			int unsigned w, h, hf, total, lag, i_in, i_out;
			w = eff_w(); h = eff_h(); hf = eff_half();
			total = w * h;
			lag = hf * w + hf;
			i_in = in_row * w + in_col;
			i_out = out_row * w + out_col;
			if (drn) begin
				if (i_in < total || i_out >= total) return;
			end else begin
				if (i_in >= total) return;
				lines[(in_row % 8) * 1024 + in_col] = red;
				in_col++;
				if (in_col >= w) begin
					in_col = 0;
					in_row++;
				end
				i_in++;
				if (i_in - i_out <= lag) return;
			end
			owed.push_back('{window_sd(out_row, out_col, w, h, hf), i_out == total - 1});
			out_col++;
			if (out_col >= w) begin
				out_col = 0;
				out_row++;
			end
			if (i_out + 1 >= total) clear_pos();
		endfunction

		// whole frame is in, results still to come
		function bit results_owed();
			int unsigned w;
			w = eff_w();
			return (in_row * w + in_col >= w * eff_h()) && (out_row * w + out_col < w * eff_h());
		endfunction

		function void check_result(bit [10:0] sd, bit last);
			sd_result_t e;
			if (owed.size() == 0) begin
				$error("unexpected result std_dev_q4=%0d frame_last=%0d", sd, last);
				errors++;
				return;
			end
			e = owed.pop_front();
			if (e.sd !== sd) begin
				$error("std_dev_q4 expected %0d actual %0d", e.sd, sd);
				errors++;
			end
			if (e.last !== last) begin
				$error("frame_last expected %0d actual %0d", e.last, last);
				errors++;
			end
		endfunction
	endclass

	logic        clk = 0;
	logic        arst_n = 0;
	logic        psel = 0, penable = 0, pwrite = 0;
	logic [3:0]  paddr = '0;
	logic [31:0] pwdata = '0;
	logic [31:0] prdata;
	logic        pready;
	logic        s_tvalid = 0;
	logic        s_tready;
	logic [7:0]  s_tdata = '0;   // [7:0] red_sample
	logic        s_tuser = 0;    // [0] drain
	logic        m_tvalid;
	logic        m_tready = 0;
	logic [15:0] m_tdata;        // [10:0] std_dev_q4, [15:11] zero
	logic        m_tlast;        // frame_last

	lwsd_scoreboard sb = new();
	int  pixels_sent;
	int  results_seen;
	bit  tx_quiet, rx_quiet;

	local_window_std_deviation uut (.*);

	always #2 clk = ~clk;

	// output monitor
	always @(posedge clk)
		if (arst_n && m_tvalid && m_tready) begin
			sb.check_result(m_tdata[10:0], m_tlast);
			results_seen++;
		end

	// receiver: random holds, one long hold to back the block up
	initial begin
		int gap;
		bit held;
		held = 0;
		wait (arst_n);
		forever begin
			if (!held && results_seen >= 300) begin
				held = 1;
				m_tready <= 0;
				repeat (600) @(posedge clk);
			end
			if (results_seen % 40 == 0) rx_quiet = ($urandom_range(0, 3) == 0);
			gap = rx_quiet ? 0 : $urandom_range(0, 10);
			if (gap > 0) begin
				m_tready <= 0;
				repeat (gap) @(posedge clk);
			end
			m_tready <= 1;
			do @(posedge clk); while (!m_tvalid);
		end
	end

	task automatic send_beat(bit [7:0] red, bit drn);
		int gap;
		gap = tx_quiet ? 0 : $urandom_range(0, 10);
		if (gap > 0) begin
			s_tvalid <= 0;
			repeat (gap) @(posedge clk);
		end
		s_tvalid <= 1;
		s_tdata <= red;
		s_tuser <= drn;
		do @(posedge clk); while (!s_tready);
		sb.note_beat(red, drn);
		if (!drn) pixels_sent++;
	endtask

	task automatic go_idle();
		s_tvalid <= 0;
		while (sb.owed.size() != 0) @(posedge clk);
		repeat (300) @(posedge clk);
	endtask

	task automatic reg_write(logic [1:0] idx, int unsigned val);
		go_idle();
		psel <= 1; penable <= 0; pwrite <= 1;
		paddr <= {idx, 2'b00};
		pwdata <= val;
		@(posedge clk);
		penable <= 1;
		@(posedge clk);
		sb.write_reg(idx, val);
		psel <= 0; penable <= 0; pwrite <= 0;
	endtask

	function automatic bit [7:0] pick_red();
		case ($urandom_range(0, 5))
			0: return 8'h00;
			1: return 8'hFF;
			default: return $urandom_range(0, 255);
		endcase
	endfunction

	// one frame (or its first cut pixels) with optional noise beats, then drains
	task automatic play_frame(int cut, bit noisy);
		for (int i = 0; i < cut; i++) begin
			if (noisy && $urandom_range(0, 19) == 0) send_beat(pick_red(), 1);
			send_beat(pick_red(), 0);
		end
		while (sb.results_owed()) begin
			if (noisy && $urandom_range(0, 9) == 0) send_beat(pick_red(), 0);
			else send_beat(pick_red(), 1);
		end
	endtask

	initial begin
		int unsigned w, h, total;
		repeat (11) @(posedge clk);
		arst_n <= 1;
		@(posedge clk);

		// directed: extremes, borders, noise beats, clamped geometry
		tx_quiet = 1;
		reg_write(REG_WIDTH, 3);
		reg_write(REG_HEIGHT, 3);
		reg_write(REG_HALF, 1);
		send_beat(8'h00, 1);
		for (int i = 0; i < 9; i++) send_beat((i % 2) ? 8'hFF : 8'h00, 0);
		send_beat(8'h5A, 0);
		while (sb.results_owed()) send_beat(8'hA5, 1);
		reg_write(REG_WIDTH, 0);
		reg_write(REG_HEIGHT, 0);
		reg_write(REG_HALF, 0);
		play_frame(1, 0);
		reg_write(REG_WIDTH, 2);
		reg_write(REG_HEIGHT, 2);
		reg_write(REG_HALF, 3);
		play_frame(4, 0);
		reg_write(REG_WIDTH, 2047);
		reg_write(REG_HEIGHT, 8191);
		for (int i = 0; i < 5; i++) send_beat(pick_red(), 0);
		reg_write(REG_HALF, 0);
		for (int i = 0; i < 5; i++) send_beat(pick_red(), 0);

		// random phases of small frames
		while (pixels_sent < 1350) begin
			w = ($urandom_range(0, 9) == 0) ? $urandom_range(13, 40) : $urandom_range(1, 12);
			h = $urandom_range(1, 8);
			if ($urandom_range(0, 19) == 0) w = 0;
			if ($urandom_range(0, 19) == 0) h = 0;
			case ($urandom_range(0, 2))
				0: begin
					reg_write(REG_HALF, $urandom_range(0, 3));
					reg_write(REG_WIDTH, w);
					reg_write(REG_HEIGHT, h);
				end
				1: begin
					reg_write(REG_WIDTH, w);
					reg_write(REG_HEIGHT, h);
					if ($urandom_range(0, 1)) reg_write(REG_HALF, $urandom_range(0, 3));
				end
				default: reg_write(REG_HEIGHT, h);
			endcase
			total = sb.eff_w() * sb.eff_h();
			for (int f = $urandom_range(1, 3); f > 0; f--) begin
				tx_quiet = ($urandom_range(0, 3) == 0);
				if (f == 1 && $urandom_range(0, 9) == 0)
					play_frame($urandom_range(0, total - 1), 1);
				else
					play_frame(total, $urandom_range(0, 2) == 0);
			end
		end

		go_idle();
		if (sb.owed.size() != 0) begin
			$error("%0d results never arrived", sb.owed.size());
			sb.errors++;
		end
		if (sb.errors == 0)
			$display("Test completed successfully");
		else
			$display("Test completed with failures");
		$finish;
	end

	// watchdog
	initial begin
		#8000000;
		$display("Test completed with failures");
		$finish;
	end

endmodule
